@@ sv/sqlipc_pkg.sv @@
// shared types, pattern tables and verdict codes for the sql injection pattern classifier
// used by sql_injection_pattern_classifier_top; no dependencies
package sqlipc_pkg;

    localparam int NPAT   = 15;
    localparam int PATMAX = 18;
    localparam int LENW   = 5;

    // input transaction: one query byte
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_in;

    // output transaction: one verdict per query
    typedef struct packed {
        logic [1:0] severity;
        logic [1:0] category;
        logic [2:0] rule_hit;
    } t_out;

    // severity codes
    localparam logic [1:0] SEV_NONE     = 2'd0;
    localparam logic [1:0] SEV_HIGH     = 2'd1;
    localparam logic [1:0] SEV_CRITICAL = 2'd2;

    // category codes
    localparam logic [1:0] CAT_NONE   = 2'd0;
    localparam logic [1:0] CAT_INJECT = 2'd1;
    localparam logic [1:0] CAT_UNAUTH = 2'd2;

    // rule codes
    localparam logic [2:0] RULE_NONE      = 3'd0;
    localparam logic [2:0] RULE_CATALOG   = 3'd1;
    localparam logic [2:0] RULE_DDL_FILE  = 3'd2;
    localparam logic [2:0] RULE_STACKED   = 3'd3;
    localparam logic [2:0] RULE_UNION     = 3'd4;
    localparam logic [2:0] RULE_TAUTOLOGY = 3'd5;

    // pattern text, right aligned: first character sits in the highest used byte
    localparam logic [PATMAX*8-1:0] PAT_TEXT [NPAT] = '{
        {"information", "_", "schema"},
        {"pg_", "catalog"},
        {"pg_", "shadow"},
        {"pg_", "authid"},
        "drop table",
        "drop database",
        "grant ",
        " into outfile",
        "copy ",
        {"load", "_file"},
        "union",
        "select",
        "or 1=1",
        "or '1'='1",
        "or 1 = 1"
    };

    localparam logic [LENW-1:0] PAT_LEN [NPAT] = '{
        5'd18, 5'd10, 5'd9, 5'd9, 5'd10, 5'd13, 5'd6, 5'd13,
        5'd5,  5'd9,  5'd5, 5'd6, 5'd6,  5'd9,  5'd8
    };

    // pattern groups as masks over the found flags
    localparam logic [NPAT-1:0] GRP_CATALOG   = 15'h000F;
    localparam logic [NPAT-1:0] GRP_DDL_FILE  = 15'h03F0;
    localparam logic [NPAT-1:0] GRP_UNION     = 15'h0400;
    localparam logic [NPAT-1:0] GRP_SELECT    = 15'h0800;
    localparam logic [NPAT-1:0] GRP_TAUTOLOGY = 15'h7000;

    // ascii lower-case fold, only A..Z change
    function automatic logic [7:0] fold(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

    // whitespace: tab through carriage return, and space
    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

endpackage

@@ sv/sql_injection_pattern_classifier_top.sv @@
// top level of the sql injection pattern classifier: shift-and matchers and verdict register
// depends on sqlipc_pkg (types, pattern tables, codes)
//
//  channel | direction | payload        | handshake
//  --------+-----------+----------------+------------------------------
//  in      | input     | t_in  ch, last | i_in_valid / o_in_ready
//  out     | output    | t_out verdict  | o_out_valid / i_out_ready
//
// one query byte is taken every cycle while o_in_ready is high; all fifteen matchers and the semicolon
// tracker update in the same cycle from the match state registers
// the verdict lands in the output register in the cycle after the last byte is taken
// reset is synchronous, active low, and clears match state and output valid
// input stalls only while a verdict is held and the output side is not ready
module sql_injection_pattern_classifier_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sqlipc_pkg::t_in   i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output sqlipc_pkg::t_out  o_out_data
);

    logic [sqlipc_pkg::PATMAX-1:0] r_progress [sqlipc_pkg::NPAT];
    logic [sqlipc_pkg::PATMAX-1:0] n_progress [sqlipc_pkg::NPAT];
    logic [sqlipc_pkg::NPAT-1:0]   r_found;
    logic [sqlipc_pkg::NPAT-1:0]   n_found;
    logic                          r_after_semi;
    logic                          n_after_semi;
    logic                          r_stacked;
    logic                          n_stacked;
    logic                          r_out_valid;
    sqlipc_pkg::t_out              r_out_data;
    sqlipc_pkg::t_out              n_verdict;
    logic                          in_acc;
    logic [7:0]                    lc;

    // input is taken unless a verdict waits and the output side stalls
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign lc          = sqlipc_pkg::fold(i_in_data.ch);

    // shift-and step for every pattern
    always_comb begin
        logic [sqlipc_pkg::PATMAX-1:0] eq;
        int len;
        n_found = r_found;
        for (int p = 0; p < sqlipc_pkg::NPAT; p++) begin
            eq  = '0;
            len = int'(sqlipc_pkg::PAT_LEN[p]);
            for (int i = 0; i < sqlipc_pkg::PATMAX; i++) begin
                if (i < len) begin
                    eq[i] = (sqlipc_pkg::PAT_TEXT[p][8*(len-1-i) +: 8] == lc);
                end
            end
            n_progress[p] = {r_progress[p][sqlipc_pkg::PATMAX-2:0], 1'b1} & eq;
            if (n_progress[p][len-1]) begin
                n_found[p] = 1'b1;
            end
        end
    end

    // stacked statement tracking
    always_comb begin
        n_stacked    = r_stacked || (r_after_semi && !sqlipc_pkg::is_ws(i_in_data.ch));
        n_after_semi = r_after_semi || (i_in_data.ch == 8'h3B);
    end

    // verdict priority
    always_comb begin
        n_verdict.severity = sqlipc_pkg::SEV_NONE;
        n_verdict.category = sqlipc_pkg::CAT_NONE;
        n_verdict.rule_hit = sqlipc_pkg::RULE_NONE;
        if (|(n_found & sqlipc_pkg::GRP_CATALOG)) begin
            n_verdict.severity = sqlipc_pkg::SEV_CRITICAL;
            n_verdict.category = sqlipc_pkg::CAT_UNAUTH;
            n_verdict.rule_hit = sqlipc_pkg::RULE_CATALOG;
        end else if (|(n_found & sqlipc_pkg::GRP_DDL_FILE)) begin
            n_verdict.severity = sqlipc_pkg::SEV_CRITICAL;
            n_verdict.category = sqlipc_pkg::CAT_UNAUTH;
            n_verdict.rule_hit = sqlipc_pkg::RULE_DDL_FILE;
        end else if (n_stacked) begin
            n_verdict.severity = sqlipc_pkg::SEV_CRITICAL;
            n_verdict.category = sqlipc_pkg::CAT_INJECT;
            n_verdict.rule_hit = sqlipc_pkg::RULE_STACKED;
        end else if ((|(n_found & sqlipc_pkg::GRP_UNION)) &&
                     (|(n_found & sqlipc_pkg::GRP_SELECT))) begin
            n_verdict.severity = sqlipc_pkg::SEV_CRITICAL;
            n_verdict.category = sqlipc_pkg::CAT_INJECT;
            n_verdict.rule_hit = sqlipc_pkg::RULE_UNION;
        end else if (|(n_found & sqlipc_pkg::GRP_TAUTOLOGY)) begin
            n_verdict.severity = sqlipc_pkg::SEV_HIGH;
            n_verdict.category = sqlipc_pkg::CAT_INJECT;
            n_verdict.rule_hit = sqlipc_pkg::RULE_TAUTOLOGY;
        end
    end

    // match state, cleared after the last byte of a query
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < sqlipc_pkg::NPAT; p++) begin
                r_progress[p] <= '0;
            end
            r_found      <= '0;
            r_after_semi <= 1'b0;
            r_stacked    <= 1'b0;
        end else if (in_acc) begin
            if (i_in_data.last) begin
                for (int p = 0; p < sqlipc_pkg::NPAT; p++) begin
                    r_progress[p] <= '0;
                end
                r_found      <= '0;
                r_after_semi <= 1'b0;
                r_stacked    <= 1'b0;
            end else begin
                for (int p = 0; p < sqlipc_pkg::NPAT; p++) begin
                    r_progress[p] <= n_progress[p];
                end
                r_found      <= n_found;
                r_after_semi <= n_after_semi;
                r_stacked    <= n_stacked;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc && i_in_data.last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_data.last) begin
            r_out_data <= n_verdict;
        end
    end

`ifndef SYNTH
    // a last byte always yields a verdict in the next cycle
    a_verdict_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.last) |=> r_out_valid)
        else $error("verdict missing after last byte");

    // match state is clear once a query ends
    a_state_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_data.last) |=> (r_found == '0 && !r_after_semi && !r_stacked))
        else $error("match state not cleared after last byte");

    // a stacked statement needs an earlier semicolon
    a_stacked_semi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stacked |-> r_after_semi)
        else $error("stacked flag without semicolon");

    // rule and severity agree on a clean verdict
    a_none_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_data.rule_hit == sqlipc_pkg::RULE_NONE) ==
                         (r_out_data.severity == sqlipc_pkg::SEV_NONE)))
        else $error("rule and severity disagree");
`endif

endmodule
